// ----- sv/dequant_gemm_dot_accumulate_core_macros.svh -----
// Assertion macros shared by the RTL that checks itself.
`ifndef DEQUANT_GEMM_DOT_ACCUMULATE_CORE_MACROS_SVH
`define DEQUANT_GEMM_DOT_ACCUMULATE_CORE_MACROS_SVH

// Check an implication on every rising edge of clk_i outside reset.
`define DGDA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a next-cycle implication on every rising edge of clk_i outside reset.
`define DGDA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/dgda_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package dgda_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CFG_ALPHA = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_BETA  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_MIN   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_MAX   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_MODE  = 3'd4;

  localparam logic signed [31:0] ALPHA_RST = 32'sd65536;
  localparam logic signed [31:0] BETA_RST  = 32'sd0;
  localparam logic signed [31:0] MIN_RST   = 32'sd0;
  localparam logic signed [31:0] MAX_RST   = 32'sd65536;
  localparam logic               MODE_RST  = 1'b0;

  localparam logic [16:0] CODE_MAX_8  = 17'd255;
  localparam logic [16:0] CODE_MAX_16 = 17'd65535;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_ACC  = 6'b000100,
    S_MULA = 6'b001000,
    S_MULB = 6'b010000,
    S_FIN  = 6'b100000
  } state_e;

  typedef struct packed {
    logic load_item;
    logic mul_ab;
    logic acc;
    logic mul_alpha;
    logic mul_beta;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic step_busy;
    logic last_term;
  } stat_t;

endpackage
`default_nettype wire

// ----- sv/dgda_step_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module dgda_step_div
  import dgda_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               restart_i,
  input  logic signed [31:0] range_min_i,
  input  logic signed [31:0] range_max_i,
  input  logic               mode_i,
  output logic signed [31:0] step_o,
  output logic               busy_o
);

  localparam int unsigned DvdW = 34;

  logic               pend_q, pend_d;
  logic               run_q, run_d;
  logic [DvdW-1:0]    num_q, num_d;
  logic [31:0]        quo_q, quo_d;
  logic               neg_q, neg_d;
  logic               wide_q, wide_d;
  logic signed [31:0] step_q, step_d;

  logic signed [32:0] diff;
  logic [32:0]        mag;
  logic [16:0]        den_sel;
  logic [16:0]        den;
  logic [DvdW-1:0]    hi;
  logic [DvdW-1:0]    lo;
  logic [31:0]        quo_fin;

  always_comb begin
    diff    = 33'(range_max_i) - 33'(range_min_i);
    mag     = diff[32] ? 33'(-diff) : 33'(diff);
    den_sel = mode_i ? CODE_MAX_16 : CODE_MAX_8;
    den     = wide_q ? CODE_MAX_16 : CODE_MAX_8;
    // Divisor is 2^k - 1, so n = hi*2^k + lo = hi*den + (hi + lo); fold until hi is zero.
    hi      = wide_q ? (num_q >> 16) : (num_q >> 8);
    lo      = num_q & DvdW'(den);
    // A folded value below 2^k is at most den; it adds one only when equal to den.
    quo_fin = quo_q + {31'd0, (num_q == DvdW'(den))};

    pend_d = pend_q | restart_i;
    run_d  = run_q;
    num_d  = num_q;
    quo_d  = quo_q;
    neg_d  = neg_q;
    wide_d = wide_q;
    step_d = step_q;

    if (pend_q) begin
      // Load the latest register values; a fresh write keeps the request pending.
      pend_d = restart_i;
      run_d  = !restart_i;
      num_d  = DvdW'(mag) + DvdW'(den_sel >> 1);
      quo_d  = '0;
      neg_d  = diff[32];
      wide_d = mode_i;
    end else if (run_q) begin
      if (hi != '0) begin
        quo_d = quo_q + hi[31:0];
        num_d = hi + lo;
      end else begin
        step_d = neg_q ? -$signed(quo_fin) : $signed(quo_fin);
        run_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b1;
      run_q  <= 1'b0;
    end else begin
      pend_q <= pend_d;
      run_q  <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    quo_q  <= quo_d;
    neg_q  <= neg_d;
    wide_q <= wide_d;
    step_q <= step_d;
  end

  assign step_o = step_q;
  assign busy_o = pend_q || run_q;

endmodule
`default_nettype wire

// ----- sv/dgda_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
module dgda_datapath
  import dgda_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic [15:0]         a_code_i,
  input  logic signed [31:0]  b_value_i,
  input  logic signed [31:0]  prior_output_i,
  input  logic                last_term_i,
  input  cmd_t                cmd_i,
  output stat_t               stat_o,
  output logic signed [31:0]  output_value_o
);

  localparam logic signed [63:0] Half = 64'sd1 <<< (FRAC_BITS - 1);

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      sat32 = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  function automatic logic signed [63:0] rnd(input logic signed [63:0] v);
    logic signed [63:0] t;
    t   = v + Half;
    rnd = t >>> FRAC_BITS;
  endfunction

  logic signed [31:0] alpha_q, beta_q, min_q, max_q;
  logic               mode_q;
  logic               restart;

  logic signed [31:0] step;
  logic               step_busy;

  logic signed [31:0] a_q, b_q, prior_q;
  logic               last_q;
  logic signed [63:0] prod_q, term_a_q, acc_q, acc_d;
  logic signed [31:0] out_q;

  logic [15:0]        code;
  logic signed [48:0] deq_prod;
  logic signed [63:0] deq_sum;
  logic signed [31:0] mul_x, mul_y;
  logic signed [63:0] term;
  logic signed [64:0] acc_sum;
  logic signed [63:0] fin_sum;

  // Configuration registers; a known index also restarts the step divider.
  always_comb begin
    restart = 1'b0;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ALPHA, CFG_BETA, CFG_MIN, CFG_MAX, CFG_MODE: restart = 1'b1;
        default: restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= ALPHA_RST;
      beta_q  <= BETA_RST;
      min_q   <= MIN_RST;
      max_q   <= MAX_RST;
      mode_q  <= MODE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ALPHA: alpha_q <= $signed(cfg_wdata_i);
        CFG_BETA:  beta_q  <= $signed(cfg_wdata_i);
        CFG_MIN:   min_q   <= $signed(cfg_wdata_i);
        CFG_MAX:   max_q   <= $signed(cfg_wdata_i);
        CFG_MODE:  mode_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  dgda_step_div u_step_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .restart_i   (restart),
    .range_min_i (min_q),
    .range_max_i (max_q),
    .mode_i      (mode_q),
    .step_o      (step),
    .busy_o      (step_busy)
  );

  // Dequantize straight off the input beat.
  always_comb begin
    code     = mode_q ? a_code_i : {8'h00, a_code_i[7:0]};
    deq_prod = $signed({1'b0, code}) * step;
    deq_sum  = 64'(deq_prod) + 64'(min_q);
  end

  // One shared multiplier serves a*b, alpha*sum and beta*prior.
  always_comb begin
    mul_x = a_q;
    mul_y = b_q;
    if (cmd_i.mul_alpha) begin
      mul_x = alpha_q;
      mul_y = sat32(acc_q);
    end else if (cmd_i.mul_beta) begin
      mul_x = beta_q;
      mul_y = prior_q;
    end
  end

  always_comb begin
    term    = rnd(prod_q);
    acc_sum = 65'(acc_q) + 65'(term);
    if (acc_sum[64] != acc_sum[63]) begin
      acc_d = acc_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      acc_d = acc_sum[63:0];
    end
    fin_sum = term_a_q + term;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (cmd_i.load_out) begin
      acc_q <= '0;
    end else if (cmd_i.acc) begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      a_q     <= sat32(deq_sum);
      b_q     <= b_value_i;
      prior_q <= prior_output_i;
      last_q  <= last_term_i;
    end
    if (cmd_i.mul_ab || cmd_i.mul_alpha || cmd_i.mul_beta) begin
      prod_q <= mul_x * mul_y;
    end
    if (cmd_i.mul_beta) begin
      term_a_q <= term;
    end
    if (cmd_i.load_out) begin
      out_q <= sat32(fin_sum);
    end
  end

  assign stat_o.step_busy = step_busy;
  assign stat_o.last_term = last_q;
  assign output_value_o   = out_q;

endmodule
`default_nettype wire

// ----- sv/dgda_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module dgda_ctrl
  import dgda_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  always_comb begin
    in_ready_o = ((state_q == S_IDLE) || (state_q == S_ACC && !stat_i.last_term))
                 && !stat_i.step_busy;
    accept     = in_valid_i && in_ready_o;

    cmd_o           = '0;
    cmd_o.load_item = accept;
    state_d         = state_q;

    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul_ab = 1'b1;
        state_d      = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        if (stat_i.last_term) begin
          state_d = S_MULA;
        end else if (accept) begin
          state_d = S_MUL;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_MULA: begin
        cmd_o.mul_alpha = 1'b1;
        state_d         = S_MULB;
      end
      S_MULB: begin
        cmd_o.mul_beta = 1'b1;
        state_d        = S_FIN;
      end
      S_FIN: begin
        // Hold until the output register is free.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ----- sv/dequant_gemm_dot_accumulate_core.sv -----
// Flow: each term beat is dequantized and loaded, then multiplied, then accumulated while
//   the next beat loads; a last term adds alpha and beta passes through the one shared
//   32x32 multiplier, and its result is registered once the output register is free.
//   The input stalls while the step divider is busy.
// Reset: asynchronous, active low; control and config registers take their reset values
//   and the step divider folds anew, as after every write to a known register index.
`timescale 1ns / 1ps
`default_nettype none
`include "dequant_gemm_dot_accumulate_core_macros.svh"
module dequant_gemm_dot_accumulate_core
  import dgda_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  // term beats
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [15:0]         a_code_i,
  input  logic signed [31:0]  b_value_i,
  input  logic signed [31:0]  prior_output_i,
  input  logic                last_term_i,
  // result beats
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [31:0]  output_value_o
);

  // Controller sequences the shared multiplier; datapath holds every value.
  cmd_t  cmd;
  stat_t stat;

  dgda_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Datapath: config registers, step divider, dequantizer, MAC and final scaling.
  dgda_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .a_code_i       (a_code_i),
    .b_value_i      (b_value_i),
    .prior_output_i (prior_output_i),
    .last_term_i    (last_term_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .output_value_o (output_value_o)
  );

  // Never take a beat while the step is being recomputed.
  `DGDA_ASSERT_IMP(a_ready_step, in_ready_o, !stat.step_busy, "beat taken during step update")
  // A last term blocks further beats until its result is scaled.
  `DGDA_ASSERT_NXT(a_last_block, in_valid_i && in_ready_o && last_term_i, !in_ready_o,
                   "beat accepted right after a last term")
  // A known register write restarts the divider and stalls the input.
  `DGDA_ASSERT_NXT(a_cfg_block,
                   cfg_we_i && (cfg_idx_i == CFG_ALPHA || cfg_idx_i == CFG_BETA ||
                                cfg_idx_i == CFG_MIN || cfg_idx_i == CFG_MAX ||
                                cfg_idx_i == CFG_MODE),
                   !in_ready_o, "input open right after a write")

endmodule
`default_nettype wire
